/* hw/rtl/kdb_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Key debounce package
// Shared types, register indexes and reset values of the key debounce block.
// ----------------------------------------------------------------------------
package kdb_pkg;

    localparam int HISTORY_LEN_DEF = 8;
    localparam int TIME_WIDTH_DEF  = 32;

    localparam int ADVANCE_W = 8;
    localparam int LIMIT_W   = 16;
    localparam int CFG_IDX_W = 2;
    localparam int S_DATA_W  = 16;
    localparam int M_DATA_W  = 8;

    typedef enum logic [2:0] {
        EV_NONE    = 3'd0,
        EV_PRESS   = 3'd1,
        EV_RELEASE = 3'd2,
        EV_CLICK   = 3'd3,
        EV_DOUBLE  = 3'd4,
        EV_LONG    = 3'd5
    } button_event_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ACTIVE_LEVEL = 2'd0,
        REG_DOUBLE_WIN   = 2'd1,
        REG_LONG_LIMIT   = 2'd2
    } cfg_index_t;

    localparam logic               ACTIVE_LEVEL_RST = 1'b0;
    localparam logic [LIMIT_W-1:0] DOUBLE_WIN_RST   = 16'd500;
    localparam logic [LIMIT_W-1:0] LONG_LIMIT_RST   = 16'd1000;

endpackage
`default_nettype wire

/* hw/rtl/key_debounce_event_detector_top.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Key debounce and event detector
// Debounces one push button and reports press, release, click, double click
// and long press events.
// ----------------------------------------------------------------------------
// Each request goes through two registers: the input register, where the
// free-running time counter is advanced, and the result register, where the
// debounce history, the event state and the result are updated. The block
// takes one request per clock cycle while results are taken; a request moves
// on once the result register is free. The result and input registers each
// hold one request, so one more request is taken while a result waits for
// the consumer. Configuration writes are taken in every cycle.
module key_debounce_event_detector_top #(
    parameter int HISTORY_LEN = kdb_pkg::HISTORY_LEN_DEF,
    parameter int TIME_WIDTH  = kdb_pkg::TIME_WIDTH_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,

    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // time_advance[7:0], sample_valid[8], raw_level[9], detect_valid[10]
    input  wire logic [kdb_pkg::S_DATA_W-1:0]    s_tdata,

    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // button_event[2:0], debounced_level[3]
    output logic [kdb_pkg::M_DATA_W-1:0]         m_tdata,

    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [kdb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [kdb_pkg::LIMIT_W-1:0]     cfg_data
);

    localparam logic [HISTORY_LEN-1:0] ALL_ONES = {HISTORY_LEN{1'b1}};

    logic                          active_level_reg;
    logic [kdb_pkg::LIMIT_W-1:0]   double_win_reg;
    logic [kdb_pkg::LIMIT_W-1:0]   long_limit_reg;

    logic [TIME_WIDTH-1:0]         time_counter_reg;
    logic [TIME_WIDTH-1:0]         time_counter_next;

    logic                          in_valid_reg;
    logic [TIME_WIDTH-1:0]         item_time_reg;
    logic                          item_sample_reg;
    logic                          item_level_reg;
    logic                          item_detect_reg;

    logic                          out_valid_reg;
    kdb_pkg::button_event_t        out_event_reg;
    logic                          out_level_reg;

    logic [HISTORY_LEN-1:0]        history_reg, history_next;
    logic                          pressed_reg, pressed_next;
    logic                          prev_pressed_reg, prev_pressed_next;
    logic [1:0]                    click_count_reg, click_count_next;
    logic                          click_pending_reg, click_pending_next;
    logic                          release_pending_reg, release_pending_next;
    logic [1:0]                    double_count_reg, double_count_next;
    kdb_pkg::button_event_t        last_event_reg, last_event_next;
    logic [TIME_WIDTH-1:0]         hold_stamp_reg, hold_stamp_next;
    logic [TIME_WIDTH-1:0]         first_stamp_reg, first_stamp_next;
    logic [TIME_WIDTH-1:0]         hold_elapsed_reg, hold_elapsed_next;

    logic                          s_accept;
    logic                          fire;

    assign cfg_ready = 1'b1;
    assign fire      = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready  = !in_valid_reg || fire;
    assign s_accept  = s_tvalid && s_tready;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {4'b0000, out_level_reg, 3'(out_event_reg)};

    assign time_counter_next = time_counter_reg
                             + TIME_WIDTH'(s_tdata[kdb_pkg::ADVANCE_W-1:0]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_level_reg <= kdb_pkg::ACTIVE_LEVEL_RST;
            double_win_reg   <= kdb_pkg::DOUBLE_WIN_RST;
            long_limit_reg   <= kdb_pkg::LONG_LIMIT_RST;
        end else if (cfg_valid) begin
            case (kdb_pkg::cfg_index_t'(cfg_index))
                kdb_pkg::REG_ACTIVE_LEVEL: active_level_reg <= cfg_data[0];
                kdb_pkg::REG_DOUBLE_WIN:   double_win_reg   <= cfg_data;
                kdb_pkg::REG_LONG_LIMIT:   long_limit_reg   <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            time_counter_reg <= '0;
            in_valid_reg     <= 1'b0;
        end else begin
            if (s_accept) begin
                time_counter_reg <= time_counter_next;
                in_valid_reg     <= 1'b1;
            end else if (fire) begin
                in_valid_reg     <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            item_time_reg   <= time_counter_next;
            item_sample_reg <= s_tdata[8];
            item_level_reg  <= s_tdata[9];
            item_detect_reg <= s_tdata[10];
        end
    end

    always_comb begin
        logic [TIME_WIDTH-1:0] t;
        logic                  held;
        logic                  edge_seen;
        logic [TIME_WIDTH-1:0] since_first;
        logic [TIME_WIDTH-1:0] since_hold;

        t = item_time_reg;

        history_next = history_reg;
        pressed_next = pressed_reg;
        if (item_sample_reg) begin
            history_next = {history_reg[HISTORY_LEN-2:0], item_level_reg};
            if (history_next == (active_level_reg ? ALL_ONES : '0)) begin
                pressed_next = 1'b1;
            end else if (history_next == (active_level_reg ? '0 : ALL_ONES)) begin
                pressed_next = 1'b0;
            end
        end

        prev_pressed_next    = prev_pressed_reg;
        click_count_next     = click_count_reg;
        click_pending_next   = click_pending_reg;
        release_pending_next = release_pending_reg;
        double_count_next    = double_count_reg;
        last_event_next      = last_event_reg;
        hold_stamp_next      = hold_stamp_reg;
        first_stamp_next     = first_stamp_reg;
        hold_elapsed_next    = hold_elapsed_reg;
        held                 = pressed_next;
        edge_seen            = held && !prev_pressed_reg;
        since_first          = t - first_stamp_reg;
        since_hold           = edge_seen ? '0 : (t - hold_stamp_reg);

        if (item_detect_reg) begin
            prev_pressed_next = held;

            if (edge_seen) begin
                click_count_next     = click_count_reg + 2'd1;
                click_pending_next   = 1'b1;
                release_pending_next = 1'b1;
                last_event_next      = kdb_pkg::EV_PRESS;
                hold_stamp_next      = t;
            end else if (!held) begin
                release_pending_next = 1'b0;
                last_event_next      = release_pending_reg ? kdb_pkg::EV_RELEASE
                                                           : kdb_pkg::EV_NONE;
                if (click_pending_reg) begin
                    click_pending_next = 1'b0;
                    click_count_next   = click_count_reg + 2'd1;
                end
            end

            if (click_count_next == 2'd2) begin
                click_count_next  = 2'd0;
                last_event_next   = kdb_pkg::EV_CLICK;
                double_count_next = double_count_reg + 2'd1;
                if (double_count_next == 2'd1) begin
                    first_stamp_next = t;
                end
            end

            if (double_count_next == 2'd2) begin
                if (since_first <= TIME_WIDTH'(double_win_reg)) begin
                    last_event_next = kdb_pkg::EV_DOUBLE;
                end
                double_count_next = 2'd0;
            end

            if (held) begin
                if (hold_elapsed_reg >= TIME_WIDTH'(long_limit_reg)) begin
                    hold_elapsed_next    = '0;
                    hold_stamp_next      = t;
                    last_event_next      = kdb_pkg::EV_LONG;
                    click_count_next     = 2'd0;
                    click_pending_next   = 1'b0;
                    release_pending_next = 1'b1;
                end else begin
                    hold_elapsed_next    = since_hold;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            history_reg         <= '0;
            pressed_reg         <= 1'b0;
            prev_pressed_reg    <= 1'b0;
            click_count_reg     <= 2'd0;
            click_pending_reg   <= 1'b0;
            release_pending_reg <= 1'b0;
            double_count_reg    <= 2'd0;
            last_event_reg      <= kdb_pkg::EV_NONE;
            hold_stamp_reg      <= '0;
            first_stamp_reg     <= '0;
            hold_elapsed_reg    <= '0;
        end else if (fire) begin
            history_reg         <= history_next;
            pressed_reg         <= pressed_next;
            prev_pressed_reg    <= prev_pressed_next;
            click_count_reg     <= click_count_next;
            click_pending_reg   <= click_pending_next;
            release_pending_reg <= release_pending_next;
            double_count_reg    <= double_count_next;
            last_event_reg      <= last_event_next;
            hold_stamp_reg      <= hold_stamp_next;
            first_stamp_reg     <= first_stamp_next;
            hold_elapsed_reg    <= hold_elapsed_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (fire) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire) begin
            out_event_reg <= last_event_next;
            out_level_reg <= pressed_next;
        end
    end

    // Click and pair counters are folded back to zero within the same step.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !click_count_reg[1] && !double_count_reg[1])
        else $error("click or pair counter left at two or more");

    // A stalled result with a full input register must freeze the key state.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && out_valid_reg && !m_tready)
            |=> ($stable(history_reg) && $stable(last_event_reg)))
        else $error("key state changed while the result was stalled");

    // The result register reports the state that was written with it.
    assert property (@(posedge aclk) disable iff (!aresetn)
        fire |=> (out_event_reg == last_event_reg && out_level_reg == pressed_reg))
        else $error("result does not match the updated key state");

    // Without a held item the input side must be open.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !in_valid_reg |-> s_tready)
        else $error("input stalled with an empty input register");

endmodule
`default_nettype wire

/* bench/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Key debounce and event detector testbench
// Drives pin samples and detection requests into the block and compares every
// result with a cycle-free predictor of the debounce and event state. The run
// uses several register settings and random idling on both stream sides.
// ----------------------------------------------------------------------------
module testbench;

    import kdb_pkg::*;

    localparam int  CLK_HALF_NS = 5;
    localparam int  RESET_CYCLES = 8;
    localparam int  ITEMS_PER_PHASE = 160;
    localparam int  PHASES = 5;
    localparam time TIMEOUT_NS = 2_000_000;

    typedef struct packed {
        button_event_t ev;
        logic          level;
    } key_outcome_t;

    class button_event_board;
        logic               active_lvl;
        logic [LIMIT_W-1:0] dbl_window;
        logic [LIMIT_W-1:0] long_limit;
        logic [7:0]         history;
        logic               pressed;
        logic               was_pressed;
        logic [1:0]         clicks;
        logic [1:0]         pairs;
        logic               click_open;
        logic               release_open;
        button_event_t      latest;
        logic [31:0]        now;
        logic [31:0]        hold_start;
        logic [31:0]        first_click_at;
        logic [31:0]        held_for;
        key_outcome_t       awaited[$];
        int                 mismatches;

        function new();
            active_lvl = ACTIVE_LEVEL_RST;
            dbl_window = DOUBLE_WIN_RST;
            long_limit = LONG_LIMIT_RST;
            history = '0;
            pressed = 1'b0;
            was_pressed = 1'b0;
            clicks = '0;
            pairs = '0;
            click_open = 1'b0;
            release_open = 1'b0;
            latest = EV_NONE;
            now = '0;
            hold_start = '0;
            first_click_at = '0;
            held_for = '0;
            mismatches = 0;
        endfunction

        function int outstanding();
            return awaited.size();
        endfunction

        function void set_register(cfg_index_t idx, logic [LIMIT_W-1:0] value);
            case (idx)
                REG_ACTIVE_LEVEL: active_lvl = value[0];
                REG_DOUBLE_WIN:   dbl_window = value;
                REG_LONG_LIMIT:   long_limit = value;
                default: ;
            endcase
        endfunction

        function void detect_events();
            logic held;
            logic rise;
            held = pressed;
            rise = held & ~was_pressed;
            was_pressed = held;
            if (rise) begin
                clicks = clicks + 2'd1;
                click_open = 1'b1;
                release_open = 1'b1;
                latest = EV_PRESS;
                hold_start = now;
            end else if (!held) begin
                if (release_open) begin
                    release_open = 1'b0;
                    latest = EV_RELEASE;
                end else begin
                    latest = EV_NONE;
                end
                if (click_open) begin
                    click_open = 1'b0;
                    clicks = clicks + 2'd1;
                end
            end
            if (clicks == 2'd2) begin
                clicks = '0;
                latest = EV_CLICK;
                pairs = pairs + 2'd1;
                if (pairs == 2'd1)
                    first_click_at = now;
            end
            if (pairs == 2'd2) begin
                if (now - first_click_at <= {16'd0, dbl_window})
                    latest = EV_DOUBLE;
                pairs = '0;
            end
            if (held) begin
                if (held_for >= {16'd0, long_limit}) begin
                    held_for = '0;
                    hold_start = now;
                    latest = EV_LONG;
                    clicks = '0;
                    click_open = 1'b0;
                    release_open = 1'b1;
                end else begin
                    held_for = now - hold_start;
                end
            end
        endfunction

        function void note_request(logic [7:0] advance, logic sample_ok, logic level,
                                   logic detect_ok);
            key_outcome_t outcome;
            now = now + {24'd0, advance};
            if (sample_ok) begin
                history = {history[6:0], level};
                if (history == (active_lvl ? 8'hFF : 8'h00))
                    pressed = 1'b1;
                else if (history == (active_lvl ? 8'h00 : 8'hFF))
                    pressed = 1'b0;
            end
            if (detect_ok)
                detect_events();
            outcome.ev = latest;
            outcome.level = pressed;
            awaited.push_back(outcome);
        endfunction

        task report_mismatch(string msg);
            if (mismatches < 50)
                $display("mismatch at %0t: %s", $time, msg);
            mismatches++;
        endtask

        task check_result(logic [M_DATA_W-1:0] data);
            key_outcome_t want;
            if (awaited.size() == 0) begin
                report_mismatch("result arrived with no request waiting");
                return;
            end
            want = awaited.pop_front();
            if (data[2:0] !== want.ev)
                report_mismatch($sformatf("button_event got %0d, expected %0d",
                                          data[2:0], want.ev));
            if (data[3] !== want.level)
                report_mismatch($sformatf("debounced_level got %0b, expected %0b",
                                          data[3], want.level));
        endtask
    endclass

    logic                 aclk = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_tvalid = 1'b0;
    logic                 s_tready;
    logic [S_DATA_W-1:0]  s_tdata = '0;
    logic                 m_tvalid;
    logic                 m_tready = 1'b0;
    logic [M_DATA_W-1:0]  m_tdata;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [LIMIT_W-1:0]   cfg_data = '0;

    button_event_board board = new();
    int sent_count = 0;
    int sender_idle_pct = 15;
    int receiver_idle_pct = 74;

    key_debounce_event_detector_top dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #CLK_HALF_NS aclk = ~aclk;

    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready)
                board.note_request(s_tdata[7:0], s_tdata[8], s_tdata[9], s_tdata[10]);
            if (m_tvalid && m_tready)
                board.check_result(m_tdata);
        end
    end

    task automatic send_request(input logic [7:0] advance, input logic sample_ok,
                                input logic level, input logic detect_ok);
        if (sent_count < 280) begin
            sender_idle_pct = 15;
            receiver_idle_pct = 74;
        end else if (sent_count < 560) begin
            sender_idle_pct = 74;
            receiver_idle_pct = 15;
        end else begin
            sender_idle_pct = 0;
            receiver_idle_pct = 0;
        end
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {5'd0, detect_ok, level, sample_ok, advance};
        do @(posedge aclk); while (!s_tready);
        sent_count++;
    endtask

    task automatic wait_drained();
        s_tvalid <= 1'b0;
        do @(posedge aclk); while (board.outstanding() != 0);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_register(input cfg_index_t idx, input logic [LIMIT_W-1:0] value);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        board.set_register(idx, value);
    endtask

    // A gesture is mostly a bouncing press and release with random timing; some
    // gestures are cut short before the history settles, and some are pure noise.
    task automatic random_gesture(input logic act);
        int top;
        int pick;
        int held_len;
        pick = $urandom_range(99);
        case ($urandom_range(3))
            0:       top = 0;
            1:       top = 3;
            2:       top = 31;
            default: top = 255;
        endcase
        if (pick < 12) begin
            repeat ($urandom_range(12, 4))
                send_request(8'($urandom_range(255)), 1'($urandom_range(1)),
                             1'($urandom_range(1)), 1'($urandom_range(1)));
        end else begin
            held_len = (pick < 22) ? $urandom_range(7, 2) : $urandom_range(24, 8);
            repeat ($urandom_range(3))
                send_request(8'($urandom_range(top)), 1'b1, 1'($urandom_range(1)), 1'b1);
            repeat (held_len)
                send_request(8'($urandom_range(top)), $urandom_range(9) != 0, act,
                             $urandom_range(9) != 0);
            repeat ($urandom_range(3))
                send_request(8'($urandom_range(top)), 1'b1, 1'($urandom_range(1)), 1'b1);
            repeat ($urandom_range(16, 8))
                send_request(8'($urandom_range(top)), $urandom_range(9) != 0, ~act,
                             $urandom_range(9) != 0);
        end
    endtask

    initial begin : stimulus
        int i;
        int phase;
        logic act;
        logic [LIMIT_W-1:0] win;
        logic [LIMIT_W-1:0] lim;
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // With the reset settings the pin is active low. A held key runs up its
        // held time without firing, is released, and the stale held time fires a
        // long press together with the next press.
        for (i = 0; i < 8; i++)
            send_request((i == 0) ? 8'd0 : 8'd3, 1'b1, 1'b0, 1'b1);
        repeat (4) send_request(8'd255, 1'b0, 1'b1, 1'b1);
        for (i = 0; i < 8; i++)
            send_request(8'd1, 1'b1, 1'b1, i == 7);
        for (i = 0; i < 8; i++)
            send_request(8'd2, 1'b1, 1'b0, i == 7);

        for (phase = 0; phase < PHASES; phase++) begin
            wait_drained();
            case (phase)
                0: begin
                    act = 1'b1;
                    win = 16'd300;
                    lim = 16'd600;
                end
                1: begin
                    act = 1'b0;
                    win = 16'hFFFF;
                    lim = 16'd0;
                end
                2: begin
                    act = 1'b1;
                    win = 16'd0;
                    lim = 16'hFFFF;
                end
                3: begin
                    act = 1'b0;
                    win = LIMIT_W'($urandom_range(1500, 200));
                    lim = LIMIT_W'($urandom_range(3000, 100));
                end
                default: begin
                    act = 1'b1;
                    win = DOUBLE_WIN_RST;
                    lim = LONG_LIMIT_RST;
                end
            endcase
            write_register(REG_ACTIVE_LEVEL, {15'd0, act});
            write_register(REG_DOUBLE_WIN, win);
            write_register(REG_LONG_LIMIT, lim);
            while (sent_count < 28 + (phase + 1) * ITEMS_PER_PHASE)
                random_gesture(act);
        end

        wait_drained();
        repeat (10) @(posedge aclk);
        if (board.mismatches == 0 && board.outstanding() == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin : watchdog
        #(TIMEOUT_NS);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
